### rtl/core/euler_to_quaternion_defines.svh
// Assertion helpers for the Euler-to-quaternion block.
`ifndef EULER_TO_QUATERNION_DEFINES_SVH
`define EULER_TO_QUATERNION_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define EUQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define EUQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/euq_pkg.sv
package euq_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int OUT_BITS_DEF   = 16;

  // CORDIC lane: phase word is 2^32 units per turn, datapath one bit wider
  localparam int PHASE_BITS    = 32;
  localparam int CORDIC_W      = PHASE_BITS + 1;
  localparam int CORDIC_STAGES = 16;
  localparam int LANE_STAGES   = CORDIC_STAGES + 1;  // iterations + round/clamp
  localparam int MUL_STAGES    = 5;

  // inverse CORDIC gain, Q.30
  localparam int CORDIC_X0 = 652032874;

  // atan(2^-i) in phase units
  localparam logic signed [CORDIC_W-1:0] ATAN_PHASE [CORDIC_STAGES] = '{
    33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004756,
    33'sd42667331,  33'sd21354465,  33'sd10679838,  33'sd5340245,
    33'sd2670163,   33'sd1335087,   33'sd667544,    33'sd333772,
    33'sd166886,    33'sd83443,     33'sd41722,     33'sd20861
  };

endpackage

### rtl/core/euq_if.sv
interface euq_angle_if #(
  parameter int ANGLE_BITS = euq_pkg::ANGLE_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [ANGLE_BITS-1:0] roll_angle;
  logic signed [ANGLE_BITS-1:0] pitch_angle;
  logic signed [ANGLE_BITS-1:0] yaw_angle;

  modport source (output valid, output roll_angle, output pitch_angle,
                  output yaw_angle, input ready);
  modport sink   (input valid, input roll_angle, input pitch_angle,
                  input yaw_angle, output ready);
endinterface

interface euq_quat_if #(
  parameter int OUT_BITS = euq_pkg::OUT_BITS_DEF
) ();
  logic                       valid;
  logic                       ready;
  logic signed [OUT_BITS-1:0] quat_w;
  logic signed [OUT_BITS-1:0] quat_x;
  logic signed [OUT_BITS-1:0] quat_y;
  logic signed [OUT_BITS-1:0] quat_z;

  modport source (output valid, output quat_w, output quat_x, output quat_y,
                  output quat_z, input ready);
  modport sink   (input valid, input quat_w, input quat_x, input quat_y,
                  input quat_z, output ready);
endinterface

### rtl/core/euler_to_quaternion.sv
// Euler angles to unit quaternion. Roll, pitch and yaw arrive as signed
// binary angles (2^ANGLE_BITS units per turn); each is halved and run through
// its own 16-iteration CORDIC lane for sine and cosine in Q1.(OUT_BITS-1).
// The quaternion is then built in two multiply rounds: the four products of
// roll and pitch terms, then those times the yaw terms, each product rounded
// half up, each component saturated to +/-(2^(OUT_BITS-1)-1). The block takes
// one beat per cycle while the output side accepts results. Each beat passes
// through the CORDIC iteration stages (one iteration per stage), a stage that
// rounds the sines and cosines, and the multiply, round and sum stages.
// Every stage carries a valid bit and holds only while its successor is full
// and blocked, so bubbles close up under back-pressure and input ready follows
// the output ready through that valid chain.
`include "euler_to_quaternion_defines.svh"

module euler_to_quaternion #(
  parameter int ANGLE_BITS = euq_pkg::ANGLE_BITS_DEF,
  parameter int OUT_BITS   = euq_pkg::OUT_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  euq_angle_if.sink     angle_i,
  euq_quat_if.source    quat_o
);
  import euq_pkg::*;

  // pipeline map
  localparam int N     = LANE_STAGES + MUL_STAGES;
  localparam int S_P1  = LANE_STAGES;       // raw roll*pitch products
  localparam int S_P2  = LANE_STAGES + 1;   // rounded pair terms
  localparam int S_T1  = LANE_STAGES + 2;   // raw triple products
  localparam int S_T2  = LANE_STAGES + 3;   // rounded triple terms
  localparam int S_OUT = LANE_STAGES + 4;   // sums, saturation, output reg

  localparam int FRAC = OUT_BITS - 1;
  localparam int PW   = 2 * OUT_BITS;
  localparam int SW   = OUT_BITS + 2;
  localparam logic signed [PW-1:0] RNDQ = PW'(64'd1 << (FRAC - 1));
  localparam logic signed [SW-1:0] LIM  = SW'((64'd1 << FRAC) - 64'd1);
  localparam logic signed [OUT_BITS-1:0] QMIN = {1'b1, {(OUT_BITS-1){1'b0}}};

  // valid chain and per-stage load enables
  logic [N-1:0] v_q, v_d, en;

  logic signed [OUT_BITS-1:0] sr, cr, sp, cp, sy, cy;

  logic signed [PW-1:0]       p_q  [4];   // crcp, srsp, crsp, srcp
  logic signed [OUT_BITS-1:0] q_q  [4];
  logic signed [OUT_BITS-1:0] cy1_q, sy1_q, cy2_q, sy2_q;
  logic signed [PW-1:0]       t_q  [8];   // w a/b, x a/b, y a/b, z a/b
  logic signed [OUT_BITS-1:0] tr_q [8];
  logic signed [OUT_BITS-1:0] w_q, x_q, y_q, z_q;

  function automatic logic signed [OUT_BITS-1:0] rnd_q(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] s;
    s = p + RNDQ;
    return s[FRAC +: OUT_BITS];
  endfunction

  function automatic logic signed [OUT_BITS-1:0] sat(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] r;
    r = v;
    if (r > LIM) begin
      r = LIM;
    end else if (r < -LIM) begin
      r = -LIM;
    end
    return r[OUT_BITS-1:0];
  endfunction

  function automatic logic signed [PW-1:0] mul(input logic signed [OUT_BITS-1:0] a,
                                               input logic signed [OUT_BITS-1:0] b);
    return PW'(a) * PW'(b);
  endfunction

  // a stage loads when it is empty or its content moves on
  assign en[N-1] = ~v_q[N-1] | quat_o.ready;
  for (genvar k = 0; k < N - 1; k++) begin : g_en
    assign en[k] = ~v_q[k] | en[k+1];
  end

  assign v_d = {v_q[N-2:0], angle_i.valid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < N; k++) begin
        if (en[k]) begin
          v_q[k] <= v_d[k];
        end
      end
    end
  end

  assign angle_i.ready = en[0];

  // CORDIC lanes
  euq_cordic #(.ANGLE_BITS(ANGLE_BITS), .OUT_BITS(OUT_BITS)) u_roll (
    .clk_i   (clk_i),
    .en_i    (en[LANE_STAGES-1:0]),
    .angle_i (angle_i.roll_angle),
    .sin_o   (sr),
    .cos_o   (cr)
  );

  euq_cordic #(.ANGLE_BITS(ANGLE_BITS), .OUT_BITS(OUT_BITS)) u_pitch (
    .clk_i   (clk_i),
    .en_i    (en[LANE_STAGES-1:0]),
    .angle_i (angle_i.pitch_angle),
    .sin_o   (sp),
    .cos_o   (cp)
  );

  euq_cordic #(.ANGLE_BITS(ANGLE_BITS), .OUT_BITS(OUT_BITS)) u_yaw (
    .clk_i   (clk_i),
    .en_i    (en[LANE_STAGES-1:0]),
    .angle_i (angle_i.yaw_angle),
    .sin_o   (sy),
    .cos_o   (cy)
  );

  // first multiply round: roll x pitch
  always_ff @(posedge clk_i) begin
    if (en[S_P1]) begin
      p_q[0] <= mul(cr, cp);
      p_q[1] <= mul(sr, sp);
      p_q[2] <= mul(cr, sp);
      p_q[3] <= mul(sr, cp);
      cy1_q  <= cy;
      sy1_q  <= sy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[S_P2]) begin
      for (int j = 0; j < 4; j++) begin
        q_q[j] <= rnd_q(p_q[j]);
      end
      cy2_q <= cy1_q;
      sy2_q <= sy1_q;
    end
  end

  // second multiply round: pair terms x yaw
  always_ff @(posedge clk_i) begin
    if (en[S_T1]) begin
      t_q[0] <= mul(q_q[0], cy2_q);   // cr cp cy
      t_q[1] <= mul(q_q[1], sy2_q);   // sr sp sy
      t_q[2] <= mul(q_q[2], sy2_q);   // cr sp sy
      t_q[3] <= mul(q_q[3], cy2_q);   // sr cp cy
      t_q[4] <= mul(q_q[2], cy2_q);   // cr sp cy
      t_q[5] <= mul(q_q[3], sy2_q);   // sr cp sy
      t_q[6] <= mul(q_q[0], sy2_q);   // cr cp sy
      t_q[7] <= mul(q_q[1], cy2_q);   // sr sp cy
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[S_T2]) begin
      for (int j = 0; j < 8; j++) begin
        tr_q[j] <= rnd_q(t_q[j]);
      end
    end
  end

  // combine and saturate into the output register
  always_ff @(posedge clk_i) begin
    if (en[S_OUT]) begin
      w_q <= sat(SW'(tr_q[0]) + SW'(tr_q[1]));
      x_q <= sat(SW'(tr_q[2]) - SW'(tr_q[3]));
      y_q <= sat(-SW'(tr_q[4]) - SW'(tr_q[5]));
      z_q <= sat(SW'(tr_q[6]) - SW'(tr_q[7]));
    end
  end

  assign quat_o.valid  = v_q[N-1];
  assign quat_o.quat_w = w_q;
  assign quat_o.quat_x = x_q;
  assign quat_o.quat_y = y_q;
  assign quat_o.quat_z = z_q;

  // checks
  `EUQ_ASSERT_NEXT(a_beat_enters, clk_i, rst_ni, angle_i.valid && angle_i.ready, v_q[0], "accepted beat missing from first stage")
  `EUQ_ASSERT_NOW(a_full_blocks, clk_i, rst_ni, (&v_q) && !quat_o.ready, !angle_i.ready, "input taken while pipeline full and stalled")
  `EUQ_ASSERT_NOW(a_sat_range, clk_i, rst_ni, quat_o.valid, quat_o.quat_w != QMIN && quat_o.quat_x != QMIN && quat_o.quat_y != QMIN && quat_o.quat_z != QMIN, "component outside saturation range")

endmodule

### rtl/core/euq_cordic.sv
// One CORDIC lane: sine and cosine of half an angle, one iteration per stage.
module euq_cordic #(
  parameter int ANGLE_BITS = euq_pkg::ANGLE_BITS_DEF,
  parameter int OUT_BITS   = euq_pkg::OUT_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic [euq_pkg::LANE_STAGES-1:0]    en_i,
  input  logic signed [ANGLE_BITS-1:0]       angle_i,
  output logic signed [OUT_BITS-1:0]         sin_o,
  output logic signed [OUT_BITS-1:0]         cos_o
);
  import euq_pkg::*;

  localparam int FRAC = OUT_BITS - 1;
  localparam int SH   = 32 - OUT_BITS;   // Q.31 -> Q1.FRAC
  localparam int RW   = CORDIC_W + 2;
  localparam logic signed [RW-1:0] RND = RW'((64'd1 << SH) >> 1);
  localparam logic signed [RW-1:0] LIM = RW'((64'd1 << FRAC) - 64'd1);
  localparam logic signed [CORDIC_W-1:0] X0 = CORDIC_W'(CORDIC_X0);

  logic signed [ANGLE_BITS-1:0] half;
  logic [PHASE_BITS-1:0]        phase;
  logic signed [CORDIC_W-1:0]   z0;

  logic signed [CORDIC_W-1:0] x_q [CORDIC_STAGES];
  logic signed [CORDIC_W-1:0] y_q [CORDIC_STAGES];
  logic signed [CORDIC_W-1:0] z_q [CORDIC_STAGES-1];
  logic signed [OUT_BITS-1:0] sin_q, cos_q;

  // Q.30 -> Q1.FRAC, round half up, clamp symmetric
  function automatic logic signed [OUT_BITS-1:0] to_q(input logic signed [CORDIC_W-1:0] v);
    logic signed [RW-1:0] s;
    logic signed [RW-1:0] r;
    s = $signed({v[CORDIC_W-1], v, 1'b0}) + RND;
    r = s >>> SH;
    if (r > LIM) begin
      r = LIM;
    end else if (r < -LIM) begin
      r = -LIM;
    end
    return r[OUT_BITS-1:0];
  endfunction

  assign half  = angle_i >>> 1;
  assign phase = PHASE_BITS'({half, {PHASE_BITS{1'b0}}} >> ANGLE_BITS);
  assign z0    = {phase[PHASE_BITS-1], phase};

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    logic signed [CORDIC_W-1:0] xin, yin, zin;
    logic signed [CORDIC_W-1:0] xd, yd;

    if (i == 0) begin : g_first
      assign xin = X0;
      assign yin = '0;
      assign zin = z0;
    end else begin : g_next
      assign xin = x_q[i-1];
      assign yin = y_q[i-1];
      assign zin = z_q[i-1];
    end

    // rotate forward while residual phase is non-negative
    assign xd = zin[CORDIC_W-1] ? xin + (yin >>> i) : xin - (yin >>> i);
    assign yd = zin[CORDIC_W-1] ? yin - (xin >>> i) : yin + (xin >>> i);

    always_ff @(posedge clk_i) begin
      if (en_i[i]) begin
        x_q[i] <= xd;
        y_q[i] <= yd;
      end
    end

    if (i < CORDIC_STAGES - 1) begin : g_phase
      always_ff @(posedge clk_i) begin
        if (en_i[i]) begin
          z_q[i] <= zin[CORDIC_W-1] ? zin + ATAN_PHASE[i] : zin - ATAN_PHASE[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[CORDIC_STAGES]) begin
      sin_q <= to_q(y_q[CORDIC_STAGES-1]);
      cos_q <= to_q(x_q[CORDIC_STAGES-1]);
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule
